@@ design/ps2mt_pkg.sv @@
// ps2mt_pkg: shared types, constants and helpers for the PS/2 mouse packet cursor tracker.
// Used by the channel interfaces and the top level; depends on nothing else.
`default_nettype none

package ps2mt_pkg;

	// coordinate and accumulator sizing
	localparam int COORD_BITS = 12;
	localparam int ACC_BITS   = 16;
	localparam int BOUND_W    = 13;
	localparam int POS_W      = 12;
	localparam int SUM_W      = 16;
	// a 9-bit two's complement delta, negated for Y, needs 10 bits
	localparam int DELTA_W    = 10;
	localparam int CMP_W      = (BOUND_W > COORD_BITS) ? BOUND_W : COORD_BITS + 1;

	// reset values
	localparam logic [BOUND_W-1:0]    BOUND_X_RST  = BOUND_W'(1024);
	localparam logic [BOUND_W-1:0]    BOUND_Y_RST  = BOUND_W'(768);
	localparam logic [COORD_BITS-1:0] CURSOR_X_RST = COORD_BITS'(512);
	localparam logic [COORD_BITS-1:0] CURSOR_Y_RST = COORD_BITS'(384);

	// head byte bit positions
	localparam int HEAD_SYNC_BIT = 3;
	localparam int HEAD_XSGN_BIT = 4;
	localparam int HEAD_YSGN_BIT = 5;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_BOUND_X = 1'b0,
		REG_BOUND_Y = 1'b1
	} cfg_reg_t;

	// input action codes
	typedef enum logic [0:0] {
		ACT_BYTE = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef struct packed {
		logic       action;
		logic       aux_flag;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic                    btn_left;
		logic                    btn_right;
		logic                    btn_middle;
		logic signed [SUM_W-1:0] sum_dx;
		logic signed [SUM_W-1:0] sum_dy;
		logic                    packet_done;
	} out_word_t;

	// largest legal position for a bound: 0 acts as 1, above full range acts as full range
	function automatic logic [COORD_BITS-1:0] max_pos(input logic [BOUND_W-1:0] bound);
		logic [CMP_W-1:0] b_ext;
		logic [CMP_W-1:0] lim;
		b_ext = CMP_W'(bound);
		lim   = CMP_W'(1) << COORD_BITS;
		if (bound == '0)
			max_pos = '0;
		else if (b_ext >= lim)
			max_pos = '1;
		else
			max_pos = COORD_BITS'(bound - BOUND_W'(1));
	endfunction

endpackage

`default_nettype wire

@@ design/ps2mt_if.sv @@
// ps2mt channel interfaces: valid/ready channels for bytes, results and config writes.
// Payload types come from ps2mt_pkg.
`default_nettype none

interface ps2mt_in_if;
	logic                valid;
	logic                ready;
	ps2mt_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ps2mt_out_if;
	logic                 valid;
	logic                 ready;
	ps2mt_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ps2mt_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [0:0]                        index;
	logic [ps2mt_pkg::BOUND_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/ps2_mouse_packet_cursor_tracker.sv @@
// ps2_mouse_packet_cursor_tracker: top level, packet framing, cursor and accumulator update.
// Depends on ps2mt_pkg and the interfaces in ps2mt_if.sv.
//
// Usage:
//   byte_ch carries one word per controller event: action, aux_flag, rx_byte.
//   action 0 feeds a controller byte (ignored unless aux_flag); three aux bytes form a
//   packet, the first only taken when its bit 3 is set. action 1 reports the state and
//   clears the accumulated deltas. Every accepted word gives exactly one word on result_ch
//   with the clamped cursor, buttons, accumulated deltas and a packet_done flag.
//   cfg writes bound_x (index 0) and bound_y (index 1); it is always ready. The user
//   must see that it is written only while the block is idle; the block does not enforce
//   this. The stored cursor is clamped to the bounds on every word.
// Pipeline and throughput:
//   a word is registered in the input register on acceptance, its result in the result
//   register. One word per cycle is sustained while result_ch is ready; the single update
//   stage from input register to result register sets that figure.
// Reset:
//   arst_n clears framing, buttons and accumulators, centers the cursor at 512/384 and
//   restores the bounds to 1024/768. No clearing pass is needed.
// Stall:
//   while result_ch is not ready the result register holds; one more word can wait in the
//   input register, after which byte_ch.ready drops until the result is taken.
`default_nettype none

module ps2_mouse_packet_cursor_tracker (
	input  wire           clk,
	input  wire           arst_n,
	ps2mt_in_if.sink      byte_ch,
	ps2mt_out_if.source   result_ch,
	ps2mt_cfg_if.sink     cfg
);

	localparam int CB = ps2mt_pkg::COORD_BITS;
	localparam int AB = ps2mt_pkg::ACC_BITS;
	localparam int DW = ps2mt_pkg::DELTA_W;
	localparam int PW = CB + 2;

	typedef enum logic [1:0] {
		PH_HEAD  = 2'd0,
		PH_XMOVE = 2'd1,
		PH_YMOVE = 2'd2
	} phase_t;

	// configuration registers
	logic [ps2mt_pkg::BOUND_W-1:0] bound_x_q;
	logic [ps2mt_pkg::BOUND_W-1:0] bound_y_q;

	// input register
	logic                           valid_s1;
	ps2mt_pkg::in_word_t            word_s1;

	// block state
	phase_t                         phase_q;
	logic [7:0]                     head_q;
	logic [7:0]                     xmove_q;
	logic [CB-1:0]                  cursor_x_q;
	logic [CB-1:0]                  cursor_y_q;
	logic [2:0]                     buttons_q;
	logic signed [AB-1:0]           acc_dx_q;
	logic signed [AB-1:0]           acc_dy_q;

	// result register
	logic                           out_valid_q;
	ps2mt_pkg::out_word_t           out_data_q;

	// next-state values
	logic                           advance;
	logic [CB-1:0]                  max_x;
	logic [CB-1:0]                  max_y;
	logic [CB-1:0]                  cx_clamp;
	logic [CB-1:0]                  cy_clamp;
	logic signed [DW-1:0]           dx;
	logic signed [DW-1:0]           dy;
	logic [CB-1:0]                  cx_move;
	logic [CB-1:0]                  cy_move;
	logic signed [AB-1:0]           acc_dx_move;
	logic signed [AB-1:0]           acc_dy_move;
	phase_t                         phase_nx;
	logic [7:0]                     head_nx;
	logic [7:0]                     xmove_nx;
	logic [CB-1:0]                  cursor_x_nx;
	logic [CB-1:0]                  cursor_y_nx;
	logic [2:0]                     buttons_nx;
	logic signed [AB-1:0]           acc_dx_nx;
	logic signed [AB-1:0]           acc_dy_nx;
	logic signed [AB-1:0]           rep_dx;
	logic signed [AB-1:0]           rep_dy;
	logic                           done_nx;
	ps2mt_pkg::out_word_t           result_nx;

	// position plus delta, clamped to [0, max]
	function automatic logic [CB-1:0] step_pos(input logic [CB-1:0] p,
			input logic signed [DW-1:0] d, input logic [CB-1:0] mx);
		logic signed [PW-1:0] sum;
		sum = signed'({2'b00, p}) + PW'(d);
		if (sum < 0)
			step_pos = '0;
		else if (sum > signed'({2'b00, mx}))
			step_pos = mx;
		else
			step_pos = sum[CB-1:0];
	endfunction

	// saturating accumulate at the signed accumulator range
	function automatic logic signed [AB-1:0] sat_add(input logic signed [AB-1:0] a,
			input logic signed [DW-1:0] d);
		logic signed [AB:0] sum;
		sum = (AB+1)'(a) + (AB+1)'(d);
		if (sum[AB] != sum[AB-1])
			sat_add = sum[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
		else
			sat_add = sum[AB-1:0];
	endfunction

	// low result bits of an accumulator, sign extended when it is narrower
	function automatic logic [ps2mt_pkg::SUM_W-1:0] to_sum(input logic signed [AB-1:0] a);
		logic signed [31:0] ext;
		ext = 32'(a);
		to_sum = ext[ps2mt_pkg::SUM_W-1:0];
	endfunction

	// handshakes
	assign advance       = valid_s1 && (!out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;
	assign result_ch.valid = out_valid_q;
	assign result_ch.data  = out_data_q;

	// bounds clamp of the stored cursor
	assign max_x    = ps2mt_pkg::max_pos(bound_x_q);
	assign max_y    = ps2mt_pkg::max_pos(bound_y_q);
	assign cx_clamp = (cursor_x_q > max_x) ? max_x : cursor_x_q;
	assign cy_clamp = (cursor_y_q > max_y) ? max_y : cursor_y_q;

	// packet deltas: sign bit over movement byte, Y inverted
	assign dx = DW'(signed'({head_q[ps2mt_pkg::HEAD_XSGN_BIT], xmove_q}));
	assign dy = -DW'(signed'({head_q[ps2mt_pkg::HEAD_YSGN_BIT], word_s1.rx_byte}));

	assign cx_move     = step_pos(cx_clamp, dx, max_x);
	assign cy_move     = step_pos(cy_clamp, dy, max_y);
	assign acc_dx_move = sat_add(acc_dx_q, dx);
	assign acc_dy_move = sat_add(acc_dy_q, dy);

	// per-word update
	always_comb begin
		phase_nx    = phase_q;
		head_nx     = head_q;
		xmove_nx    = xmove_q;
		cursor_x_nx = cx_clamp;
		cursor_y_nx = cy_clamp;
		buttons_nx  = buttons_q;
		acc_dx_nx   = acc_dx_q;
		acc_dy_nx   = acc_dy_q;
		done_nx     = 1'b0;
		rep_dx      = acc_dx_q;
		rep_dy      = acc_dy_q;
		if (word_s1.action == ps2mt_pkg::ACT_READ) begin
			acc_dx_nx = '0;
			acc_dy_nx = '0;
		end else begin
			if (word_s1.aux_flag) begin
				unique case (phase_q)
					PH_XMOVE: begin
						xmove_nx = word_s1.rx_byte;
						phase_nx = PH_YMOVE;
					end
					PH_YMOVE: begin
						phase_nx    = PH_HEAD;
						buttons_nx  = head_q[2:0];
						acc_dx_nx   = acc_dx_move;
						acc_dy_nx   = acc_dy_move;
						cursor_x_nx = cx_move;
						cursor_y_nx = cy_move;
						done_nx     = 1'b1;
					end
					default: begin
						head_nx  = word_s1.rx_byte;
						phase_nx = word_s1.rx_byte[ps2mt_pkg::HEAD_SYNC_BIT] ? PH_XMOVE
							: PH_HEAD;
					end
				endcase
			end
			rep_dx = acc_dx_nx;
			rep_dy = acc_dy_nx;
		end
	end

	// result word
	always_comb begin
		result_nx.pos_x       = ps2mt_pkg::POS_W'(cursor_x_nx);
		result_nx.pos_y       = ps2mt_pkg::POS_W'(cursor_y_nx);
		result_nx.btn_left    = buttons_nx[0];
		result_nx.btn_right   = buttons_nx[1];
		result_nx.btn_middle  = buttons_nx[2];
		result_nx.sum_dx      = to_sum(rep_dx);
		result_nx.sum_dy      = to_sum(rep_dy);
		result_nx.packet_done = done_nx;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_x_q <= ps2mt_pkg::BOUND_X_RST;
			bound_y_q <= ps2mt_pkg::BOUND_Y_RST;
		end else if (cfg.valid) begin
			unique case (ps2mt_pkg::cfg_reg_t'(cfg.index))
				ps2mt_pkg::REG_BOUND_X: bound_x_q <= cfg.data;
				ps2mt_pkg::REG_BOUND_Y: bound_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready)
			word_s1 <= byte_ch.data;
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_HEAD;
			head_q      <= '0;
			xmove_q     <= '0;
			cursor_x_q  <= ps2mt_pkg::CURSOR_X_RST;
			cursor_y_q  <= ps2mt_pkg::CURSOR_Y_RST;
			buttons_q   <= '0;
			acc_dx_q    <= '0;
			acc_dy_q    <= '0;
		end else begin
			if (byte_ch.ready)
				valid_s1 <= byte_ch.valid;
			if (advance) begin
				phase_q     <= phase_nx;
				head_q      <= head_nx;
				xmove_q     <= xmove_nx;
				cursor_x_q  <= cursor_x_nx;
				cursor_y_q  <= cursor_y_nx;
				buttons_q   <= buttons_nx;
				acc_dx_q    <= acc_dx_nx;
				acc_dy_q    <= acc_dy_nx;
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= result_nx;
	end

	// a word held in the result register that closed a packet leaves framing at the head
	a_done_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.packet_done |-> phase_q == PH_HEAD)
		else $error("packet_done result without framing back at head");

	// a read never closes a packet and leaves the accumulators cleared
	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.action == ps2mt_pkg::ACT_READ |=>
		!out_data_q.packet_done && acc_dx_q == '0 && acc_dy_q == '0)
		else $error("read did not clear accumulators");

	// an empty result register never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> byte_ch.ready)
		else $error("input stalled with empty result register");

	// a pending word moves on whenever the receiver takes the result
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && result_ch.ready |=> out_valid_q)
		else $error("pending word not moved to result register");

endmodule

`default_nettype wire

@@ dv/ps2_mouse_packet_cursor_tracker_tb.sv @@
`timescale 1ns / 1ps
// ps2_mouse_packet_cursor_tracker_tb: self-checking bench for the PS/2 packet cursor tracker.
// Depends on ps2mt_pkg, the channel interfaces in ps2mt_if.sv and the tracker top level.

module ps2_mouse_packet_cursor_tracker_tb;

	localparam int CYCLE_LIMIT = 200000;

	// framing positions inside a packet
	localparam logic [1:0] AT_HEAD  = 2'd0;
	localparam logic [1:0] AT_XMOVE = 2'd1;
	localparam logic [1:0] AT_YMOVE = 2'd2;

	typedef struct packed {
		logic                 fixed;
		ps2mt_pkg::in_word_t  stim;
		ps2mt_pkg::out_word_t want;
	} dir_row_t;

	// directed words; rows marked fixed carry their result typed in
	localparam int DIR_ROWS = 21;
	localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
		// reset state, read, ignored byte, bad first bytes
		'{1'b1, '{ps2mt_pkg::ACT_READ, 1'b0, 8'h00},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_BYTE, 1'b0, 8'hFF},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h00},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'hF7},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		// packet with all buttons and both signs, read and ignored byte in the middle
		'{1'b1, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h3F},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_READ, 1'b1, 8'hFF},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h00},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_BYTE, 1'b0, 8'h55},
			'{12'd512, 12'd384, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h00},
			'{12'd256, 12'd640, 1'b1, 1'b1, 1'b1, -16'sd256, 16'sd256, 1'b1}},
		// read reports the sums before the clear
		'{1'b1, '{ps2mt_pkg::ACT_READ, 1'b0, 8'h00},
			'{12'd256, 12'd640, 1'b1, 1'b1, 1'b1, -16'sd256, 16'sd256, 1'b0}},
		'{1'b1, '{ps2mt_pkg::ACT_READ, 1'b0, 8'h00},
			'{12'd256, 12'd640, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0}},
		// overflow bits set, largest positive moves
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'hC8}, '0},
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'hFF}, '0},
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'hFF}, '0},
		// middle button, mid-range moves
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h0C}, '0},
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h80}, '0},
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h7F}, '0},
		// left button, negative X, positive raw Y
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h19}, '0},
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h01}, '0},
		'{1'b0, '{ps2mt_pkg::ACT_BYTE, 1'b1, 8'h80}, '0},
		'{1'b0, '{ps2mt_pkg::ACT_READ, 1'b1, 8'hAA}, '0}
	};

	logic clk;
	logic arst_n;

	ps2mt_in_if  byte_if ();
	ps2mt_out_if result_if ();
	ps2mt_cfg_if cfg_if ();

	ps2_mouse_packet_cursor_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_if),
		.result_ch(result_if),
		.cfg      (cfg_if)
	);

	// tracker state as the bench sees it
	logic [ps2mt_pkg::BOUND_W-1:0] bound_x_q;
	logic [ps2mt_pkg::BOUND_W-1:0] bound_y_q;
	logic [1:0]         frame_phase;
	logic [7:0]         head_q;
	logic [7:0]         xbyte_q;
	logic [2:0]         btn_q;
	int                 cur_x;
	int                 cur_y;
	int                 acc_x;
	int                 acc_y;

	ps2mt_pkg::out_word_t pending_results [$];

	int errors;
	int cycle_count;
	int items_sent;
	int results_seen;
	int packets_done;
	int reads_done;
	int acc_clips;
	int bound_sets;
	int src_idle_pct;
	int snk_stall_pct;

	always #1 clk = ~clk;

	function automatic int clamp_coord(int p, int bound);
		if (p < 0)
			p = 0;
		if (p >= bound)
			p = bound - 1;
		return p;
	endfunction

	function automatic int clip_acc(int v);
		int hi;
		hi = (1 << (ps2mt_pkg::ACC_BITS - 1)) - 1;
		if (v > hi) begin
			acc_clips++;
			return hi;
		end
		if (v < -hi - 1) begin
			acc_clips++;
			return -hi - 1;
		end
		return v;
	endfunction

	// advance the tracker state by one word and give its result
	function automatic ps2mt_pkg::out_word_t track_word(ps2mt_pkg::in_word_t w);
		int lim;
		int bx;
		int by;
		int dx;
		int dy;
		ps2mt_pkg::out_word_t r;
		lim = 1 << ps2mt_pkg::COORD_BITS;
		bx = (bound_x_q == 0) ? 1 : ((int'(bound_x_q) > lim) ? lim : int'(bound_x_q));
		by = (bound_y_q == 0) ? 1 : ((int'(bound_y_q) > lim) ? lim : int'(bound_y_q));
		r = '0;
		// stored cursor follows the bounds on every word
		cur_x = clamp_coord(cur_x, bx);
		cur_y = clamp_coord(cur_y, by);
		if (w.action == ps2mt_pkg::ACT_READ) begin
			r.sum_dx = acc_x[ps2mt_pkg::SUM_W-1:0];
			r.sum_dy = acc_y[ps2mt_pkg::SUM_W-1:0];
			acc_x = 0;
			acc_y = 0;
			reads_done++;
		end else begin
			if (w.aux_flag) begin
				case (frame_phase)
					AT_XMOVE: begin
						xbyte_q = w.rx_byte;
						frame_phase = AT_YMOVE;
					end
					AT_YMOVE: begin
						dx = int'(xbyte_q) - (head_q[ps2mt_pkg::HEAD_XSGN_BIT] ? 256 : 0);
						dy = -(int'(w.rx_byte) - (head_q[ps2mt_pkg::HEAD_YSGN_BIT] ? 256 : 0));
						frame_phase = AT_HEAD;
						btn_q = head_q[2:0];
						acc_x = clip_acc(acc_x + dx);
						acc_y = clip_acc(acc_y + dy);
						cur_x = clamp_coord(cur_x + dx, bx);
						cur_y = clamp_coord(cur_y + dy, by);
						r.packet_done = 1'b1;
						packets_done++;
					end
					default: begin
						head_q = w.rx_byte;
						frame_phase = w.rx_byte[ps2mt_pkg::HEAD_SYNC_BIT] ? AT_XMOVE : AT_HEAD;
					end
				endcase
			end
			r.sum_dx = acc_x[ps2mt_pkg::SUM_W-1:0];
			r.sum_dy = acc_y[ps2mt_pkg::SUM_W-1:0];
		end
		r.pos_x = cur_x[ps2mt_pkg::POS_W-1:0];
		r.pos_y = cur_y[ps2mt_pkg::POS_W-1:0];
		r.btn_left = btn_q[0];
		r.btn_right = btn_q[1];
		r.btn_middle = btn_q[2];
		return r;
	endfunction

	// hand one word to the tracker, predicting its result on acceptance
	task automatic send_word(ps2mt_pkg::in_word_t w, bit use_fixed = 1'b0,
			ps2mt_pkg::out_word_t fixed = '0);
		int gap;
		ps2mt_pkg::out_word_t predicted;
		gap = 0;
		while ($urandom_range(0, 99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data <= w;
		do
			@(posedge clk);
		while (!byte_if.ready);
		predicted = track_word(w);
		pending_results.push_back(use_fixed ? fixed : predicted);
		if (w.action == ps2mt_pkg::ACT_READ || w.aux_flag)
			items_sent++;
	endtask

	// three aux bytes, optionally with stray words in between
	task automatic send_packet(logic [7:0] head, logic [7:0] xb, logic [7:0] yb, bit noisy);
		logic [7:0] seq [3];
		seq = '{head, xb, yb};
		for (int i = 0; i < 3; i++) begin
			if (noisy && i > 0 && $urandom_range(0, 9) == 0)
				send_word('{ps2mt_pkg::ACT_BYTE, 1'b0, 8'($urandom_range(0, 255))});
			if (noisy && i > 0 && $urandom_range(0, 19) == 0)
				send_word('{ps2mt_pkg::ACT_READ, 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255))});
			send_word('{ps2mt_pkg::ACT_BYTE, 1'b1, seq[i]});
		end
	endtask

	task automatic write_bounds(logic [ps2mt_pkg::BOUND_W-1:0] bx,
			logic [ps2mt_pkg::BOUND_W-1:0] by);
		for (int i = 0; i < 2; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= (i == 0) ? ps2mt_pkg::REG_BOUND_X : ps2mt_pkg::REG_BOUND_Y;
			cfg_if.data <= (i == 0) ? bx : by;
			do
				@(posedge clk);
			while (!cfg_if.ready);
			if (i == 0)
				bound_x_q = bx;
			else
				bound_y_q = by;
		end
		cfg_if.valid <= 1'b0;
		bound_sets++;
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// random traffic; a drift run pushes one direction hard to reach the clip limits
	task automatic run_traffic(bit drift, int target);
		int start;
		int pick;
		bit xneg;
		bit yneg;
		logic [7:0] head;
		start = items_sent;
		if (drift) begin
			xneg = 1'($urandom_range(0, 1));
			yneg = 1'($urandom_range(0, 1));
			repeat (140) begin
				head = {2'($urandom_range(0, 3)), yneg, xneg, 1'b1, 3'($urandom_range(0, 7))};
				send_packet(head,
					xneg ? 8'($urandom_range(1, 16)) : 8'($urandom_range(240, 255)),
					yneg ? 8'($urandom_range(1, 16)) : 8'($urandom_range(240, 255)), 1'b0);
			end
			send_word('{ps2mt_pkg::ACT_READ, 1'b0, 8'h00});
		end
		while (items_sent - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				send_packet(8'($urandom_range(0, 255)) | 8'h08, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b1);
			else if (pick < 78)
				send_word('{ps2mt_pkg::ACT_READ, 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255))});
			else if (pick < 86)
				send_word('{ps2mt_pkg::ACT_BYTE, 1'b0, 8'($urandom_range(0, 255))});
			else if (pick < 93)
				send_word('{ps2mt_pkg::ACT_BYTE, 1'b1, 8'($urandom_range(0, 255)) & 8'hF7});
			else
				send_word(ps2mt_pkg::in_word_t'(10'($urandom_range(0, 1023))));
		end
	endtask

	// result side stalls at random
	always @(posedge clk)
		result_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

	// compare every result word with the oldest prediction
	always @(posedge clk) begin
		ps2mt_pkg::out_word_t want;
		ps2mt_pkg::out_word_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = result_if.data;
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word at cycle %0d", cycle_count);
			end else begin
				want = pending_results.pop_front();
				if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y
						|| got.btn_left !== want.btn_left || got.btn_right !== want.btn_right
						|| got.btn_middle !== want.btn_middle || got.sum_dx !== want.sum_dx
						|| got.sum_dy !== want.sum_dy
						|| got.packet_done !== want.packet_done) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch @%0d: want x=%0d y=%0d lrm=%b%b%b dx=%0d dy=%0d done=%b",
							cycle_count, want.pos_x, want.pos_y, want.btn_left,
							want.btn_right, want.btn_middle, $signed(want.sum_dx),
							$signed(want.sum_dy), want.packet_done);
						$display("                 got  x=%0d y=%0d lrm=%b%b%b dx=%0d dy=%0d done=%b",
							got.pos_x, got.pos_y, got.btn_left, got.btn_right,
							got.btn_middle, $signed(got.sum_dx), $signed(got.sum_dy),
							got.packet_done);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("ps2_mouse_packet_cursor_tracker verification failed");
			$finish;
		end
	end

	initial begin
		logic [ps2mt_pkg::BOUND_W-1:0] bx;
		logic [ps2mt_pkg::BOUND_W-1:0] by;
		bit drift;
		clk = 1'b0;
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.data = '0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = ps2mt_pkg::REG_BOUND_X;
		cfg_if.data = '0;
		errors = 0;
		cycle_count = 0;
		items_sent = 0;
		results_seen = 0;
		packets_done = 0;
		reads_done = 0;
		acc_clips = 0;
		bound_sets = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		// reset values of the tracker
		bound_x_q = ps2mt_pkg::BOUND_W'(1024);
		bound_y_q = ps2mt_pkg::BOUND_W'(768);
		frame_phase = AT_HEAD;
		head_q = '0;
		xbyte_q = '0;
		btn_q = '0;
		cur_x = 512;
		cur_y = 384;
		acc_x = 0;
		acc_y = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at reset bounds
		for (int i = 0; i < DIR_ROWS; i++)
			send_word(DIR_TABLE[i].stim, DIR_TABLE[i].fixed, DIR_TABLE[i].want);

		// bound settings and idling patterns, one per pass
		for (int p = 0; p < 7; p++) begin
			drift = 1'b0;
			case (p)
				0: begin
					bx = ps2mt_pkg::BOUND_W'(1024);
					by = ps2mt_pkg::BOUND_W'(768);
					drift = 1'b1;
				end
				1: begin
					bx = ps2mt_pkg::BOUND_W'(1);
					by = ps2mt_pkg::BOUND_W'(1);
				end
				2: begin
					bx = ps2mt_pkg::BOUND_W'(4096);
					by = ps2mt_pkg::BOUND_W'(4096);
					drift = 1'b1;
				end
				3: begin
					bx = ps2mt_pkg::BOUND_W'(0);
					by = ps2mt_pkg::BOUND_W'(8191);
				end
				4: begin
					bx = ps2mt_pkg::BOUND_W'(8191);
					by = ps2mt_pkg::BOUND_W'(0);
				end
				5: begin
					bx = ps2mt_pkg::BOUND_W'($urandom_range(1, 4096));
					by = ps2mt_pkg::BOUND_W'($urandom_range(1, 4096));
				end
				default: begin
					bx = ps2mt_pkg::BOUND_W'($urandom_range(0, 8191));
					by = ps2mt_pkg::BOUND_W'($urandom_range(0, 8191));
				end
			endcase
			byte_if.valid <= 1'b0;
			drain_results();
			case (p % 4)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 46;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 46;
				end
				default: begin
					src_idle_pct = 35;
					snk_stall_pct = 35;
				end
			endcase
			write_bounds(bx, by);
			run_traffic(drift, 140);
		end

		byte_if.valid <= 1'b0;
		drain_results();
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			errors++;

		$display("%0d result words checked: %0d packets, %0d reads, %0d accumulator clips",
			results_seen, packets_done, reads_done, acc_clips);
		$display("%0d bound settings, %0d mismatches", bound_sets, errors);
		if (errors == 0)
			$display("ps2_mouse_packet_cursor_tracker verification clean");
		else
			$display("ps2_mouse_packet_cursor_tracker verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/ps2mt_pkg.sv
design/ps2mt_if.sv
design/ps2_mouse_packet_cursor_tracker.sv
dv/ps2_mouse_packet_cursor_tracker_tb.sv
